[rtl/core/dvr_pkg.sv]
// Shared types and constants of the disc reveal visibility map.
package dvr_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REVEAL = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] REG_GRID_W = 2'd0;
  localparam logic [1:0] REG_GRID_H = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;
  localparam logic [1:0] REG_FADE   = 2'd3;

  localparam int CFG_DW = 16;
  localparam logic [12:0] COUNT_MAX = 13'd8191;
  localparam logic [7:0]  ALPHA_RST = 8'd255;
  localparam logic [15:0] FADE_RST  = 16'd1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  x_coord;
    logic [7:0]  y_coord;
    logic [6:0]  radius;
    logic [15:0] delta_time;
  } in_t;

  typedef struct packed {
    logic        revealed_flag;
    logic [7:0]  alpha;
    logic [12:0] revealed_total;
  } out_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic tick;
    logic setup;
    logic scan;
    logic qev;
    logic qmul;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic regrid;
    logic clr_last;
    logic empty;
    logic scan_last;
    logic div_last;
  } sts_t;

endpackage

[rtl/core/dvr_ram.sv]
// Generic simple dual-port RAM with registered read.
module dvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dvr_ctrl.sv]
// Sequencer of the disc reveal visibility map.
module dvr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    op,
  input  dvr_pkg::sts_t sts,
  output dvr_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_TICK  = 11'b00000000100,
    S_SETUP = 11'b00000001000,
    S_SCAN  = 11'b00000010000,
    S_DRAIN = 11'b00000100000,
    S_QRD   = 11'b00001000000,
    S_QEV   = 11'b00010000000,
    S_QMUL  = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (op)
            dvr_pkg::OP_TICK:   state_nxt = S_TICK;
            dvr_pkg::OP_REVEAL: state_nxt = S_SETUP;
            dvr_pkg::OP_QUERY:  state_nxt = S_QRD;
            default:            state_nxt = S_EMIT;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.empty ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_EMIT;
      S_QRD:   state_nxt = S_QEV;
      S_QEV: begin
        cmd.qev   = 1'b1;
        state_nxt = S_QMUL;
      end
      S_QMUL: begin
        cmd.qmul  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // grid resize restarts the sweep
    if (sts.regrid) begin
      state_nxt = S_CLEAR;
      cmd.clr   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/core/dvr_dp.sv]
// Datapath: config registers, map RAM, disc scanner, time, count and alpha divider.
module dvr_dp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dvr_pkg::in_t                  in_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [dvr_pkg::CFG_DW-1:0]    cfg_wdata,
  input  dvr_pkg::cmd_t                 cmd,
  output dvr_pkg::sts_t                 sts,
  output logic                          out_valid,
  output dvr_pkg::out_t                 out_data
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW    = TIME_BITS + 1;

  // config
  logic [6:0]  grid_w_r, grid_h_r;
  logic [7:0]  ua_r;
  logic [15:0] fd_r;

  dvr_pkg::in_t in_r;
  logic [12:0]          count_r;
  logic [TIME_BITS-1:0] elapsed_r;
  logic [AW-1:0]        clr_addr_r;

  logic regrid;
  assign regrid = cfg_we && (cfg_index == dvr_pkg::REG_GRID_W ||
                             cfg_index == dvr_pkg::REG_GRID_H);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= '0;
      grid_h_r <= '0;
      ua_r     <= dvr_pkg::ALPHA_RST;
      fd_r     <= dvr_pkg::FADE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dvr_pkg::REG_GRID_W: grid_w_r <= cfg_wdata[6:0];
        dvr_pkg::REG_GRID_H: grid_h_r <= cfg_wdata[6:0];
        dvr_pkg::REG_ALPHA:  ua_r     <= cfg_wdata[7:0];
        dvr_pkg::REG_FADE:   fd_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // in-use grid size, clipped to the maximum
  logic [8:0] used_w, used_h;
  assign used_w = ({2'b0, grid_w_r} > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : {2'b0, grid_w_r};
  assign used_h = ({2'b0, grid_h_r} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {2'b0, grid_h_r};

  // disc bounding box, signed
  logic signed [10:0] lo_x, hi_x, lo_y, hi_y, wm1, hm1, x0, x1, y0, y1;
  always_comb begin
    lo_x = $signed({3'b0, in_r.x_coord}) - $signed({4'b0, in_r.radius});
    hi_x = $signed({3'b0, in_r.x_coord}) + $signed({4'b0, in_r.radius});
    lo_y = $signed({3'b0, in_r.y_coord}) - $signed({4'b0, in_r.radius});
    hi_y = $signed({3'b0, in_r.y_coord}) + $signed({4'b0, in_r.radius});
    wm1  = $signed({2'b0, used_w}) - 11'sd1;
    hm1  = $signed({2'b0, used_h}) - 11'sd1;
    x0   = (lo_x < 0) ? 11'sd0 : lo_x;
    y0   = (lo_y < 0) ? 11'sd0 : lo_y;
    x1   = (hi_x > wm1) ? wm1 : hi_x;
    y1   = (hi_y > hm1) ? hm1 : hi_y;
  end

  // scanner
  logic [XW-1:0] x_r, x0_r, x1_r;
  logic [YW-1:0] y_r, y1_r;
  logic [13:0]   r2_r;

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.setup) begin
      x_r  <= x0[XW-1:0];
      x0_r <= x0[XW-1:0];
      x1_r <= x1[XW-1:0];
      y_r  <= y0[YW-1:0];
      y1_r <= y1[YW-1:0];
      r2_r <= 14'(in_r.radius * in_r.radius);
    end else if (cmd.scan) begin
      if (x_r == x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + YW'(1);
      end else begin
        x_r <= x_r + XW'(1);
      end
    end
  end

  logic signed [9:0] dx, dy;
  assign dx = $signed({2'b0, x_r}) - $signed({2'b0, in_r.x_coord});
  assign dy = $signed({2'b0, y_r}) - $signed({2'b0, in_r.y_coord});

  // read stage of the scan
  logic [16:0]   sqx_r, sqy_r;
  logic          v_p1_r;
  logic [AW-1:0] addr_p1_r, scan_addr, q_addr;

  assign scan_addr = AW'(int'(y_r) * MAX_WIDTH + int'(x_r));
  assign q_addr    = AW'(int'(in_r.y_coord[YW-1:0]) * MAX_WIDTH + int'(in_r.x_coord[XW-1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p1_r <= 1'b0;
    end else begin
      v_p1_r <= cmd.scan;
    end
    sqx_r     <= 17'(dx * dx);
    sqy_r     <= 17'(dy * dy);
    addr_p1_r <= scan_addr;
  end

  // map RAM: {revealed flag, stamp}
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic          in_disc, mark;

  assign in_disc = ({1'b0, sqx_r} + {1'b0, sqy_r}) <= {4'b0, r2_r};
  assign mark    = v_p1_r && in_disc && !ram_rdata[TIME_BITS];

  assign ram_we    = cmd.clr || mark;
  assign ram_waddr = cmd.clr ? clr_addr_r : addr_p1_r;
  assign ram_wdata = cmd.clr ? '0 : {1'b1, elapsed_r};
  assign ram_raddr = cmd.scan ? scan_addr : q_addr;

  dvr_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // time, count, clear sweep
  logic [TIME_BITS:0] el_sum;
  assign el_sum = {1'b0, elapsed_r} + (TIME_BITS + 1)'(in_r.delta_time);

  always_ff @(posedge clk) begin
    if (!rst_n || regrid) begin
      count_r    <= '0;
      elapsed_r  <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.tick) elapsed_r <= el_sum[TIME_BITS] ? '1 : el_sum[TIME_BITS-1:0];
      if (mark && count_r != dvr_pkg::COUNT_MAX) count_r <= count_r + 13'd1;
      if (cmd.clr) clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // query: hit check, fade, restoring divider
  logic                 hit_r, far_r;
  logic [TIME_BITS-1:0] since_r;
  logic [23:0]          rem_r;
  logic [7:0]           q_r;
  logic [2:0]           step_r;
  logic                 inb;
  logic [24:0]          trial;

  assign inb   = ({1'b0, in_r.x_coord} < used_w) && ({1'b0, in_r.y_coord} < used_h);
  assign trial = {1'b0, rem_r} - (25'(fd_r) << step_r);

  always_ff @(posedge clk) begin
    if (cmd.qev) begin
      hit_r   <= inb && ram_rdata[TIME_BITS];
      since_r <= (elapsed_r >= ram_rdata[TIME_BITS-1:0]) ?
                 elapsed_r - ram_rdata[TIME_BITS-1:0] : '0;
    end
    if (cmd.qmul) begin
      far_r  <= since_r >= TIME_BITS'(fd_r);
      rem_r  <= 24'(ua_r * (fd_r - since_r[15:0]));
      q_r    <= '0;
      step_r <= 3'd7;
    end else if (cmd.div) begin
      if (!trial[24]) begin
        rem_r     <= trial[23:0];
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 3'd1;
    end
  end

  // result
  logic          is_q;
  dvr_pkg::out_t res;
  assign is_q = (in_r.op == dvr_pkg::OP_QUERY);

  always_comb begin
    res                = '0;
    res.revealed_total = count_r;
    if (is_q) begin
      res.revealed_flag = hit_r;
      res.alpha         = !hit_r ? ua_r : (far_r ? 8'd0 : q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) out_data <= res;
  end

  assign sts.regrid    = regrid;
  assign sts.clr_last  = (clr_addr_r == AW'(CELLS - 1));
  assign sts.empty     = (x0 > x1) || (y0 > y1);
  assign sts.scan_last = (x_r == x1_r) && (y_r == y1_r);
  assign sts.div_last  = (step_r == 3'd0);

endmodule

[rtl/core/disc_reveal_visibility_map.sv]
// Top level of the disc reveal visibility map: sequencer plus datapath.
// Every op ends in a result strobe; a reveal scans the cells of the clipped bounding box of the
// disc (none when the box is empty), one cell per cycle, set by the single read/write pair of
// the map RAM. One transaction at a time.
// Reset, and any write of grid width or height, runs a clearing sweep over all MAX_WIDTH*MAX_HEIGHT
// cells (4096 by default) with busy high. Results strobe one cycle; no receiver stall.
module disc_reveal_visibility_map #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input transactions
  input  logic                       start,
  output logic                       busy,
  input  dvr_pkg::in_t               in_data,
  // results
  output logic                       out_valid,
  output dvr_pkg::out_t              out_data,
  // config writes
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [dvr_pkg::CFG_DW-1:0] cfg_wdata
);

  dvr_pkg::cmd_t cmd;
  dvr_pkg::sts_t sts;

  // controller: decodes op on accept, walks scan/query/divide steps
  dvr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: RAM holds {flag, stamp} per cell, scan is a one-stage
  // read-then-write pipeline, alpha comes from an 8-step divider
  dvr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
